@@ design/lag_pkg.sv @@
package lag_pkg;

    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int REQ_W      = 2;
    localparam int IDX_W      = 6;
    localparam int ROW_BITS_W = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic clear_all;
        logic set_read;
        logic set_write;
        logic read_row;
        logic step_run;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic step_last;
    } t_dp_stat;

endpackage

@@ design/life_automaton_grid_core.sv @@
// Set runs ST_SET_RD then ST_SET_WR, clear ST_CLR, read ST_READ, step ST_STEP,
// each then ST_DONE (the step sweep reads one row and writes one row per cycle).
// One request is processed at a time; the next is taken the cycle after its
// result is loaded into the output register, even while that result waits.
// Synchronous active-low reset marks every grid row dead through per-row valid bits.
module life_automaton_grid_core #(
    parameter int GRID_ROWS = lag_pkg::GRID_ROWS,
    parameter int GRID_COLS = lag_pkg::GRID_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lag_pkg::REQ_W-1:0]      i_req_type,
    input  logic [lag_pkg::IDX_W-1:0]      i_row_index,
    input  logic [lag_pkg::IDX_W-1:0]      i_col_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lag_pkg::ROW_BITS_W-1:0] o_row_bits,
    output logic                           o_op_done
);

    lag_pkg::t_dp_cmd  cmd;
    lag_pkg::t_dp_stat stat;

    lag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lag_dpath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req_type),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_row_bits  (o_row_bits),
        .o_op_done   (o_op_done)
    );

endmodule

@@ design/lag_dpath.sv @@
module lag_dpath #(
    parameter int GRID_ROWS = lag_pkg::GRID_ROWS,
    parameter int GRID_COLS = lag_pkg::GRID_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lag_pkg::REQ_W-1:0]      i_req_type,
    input  logic [lag_pkg::IDX_W-1:0]      i_row_index,
    input  logic [lag_pkg::IDX_W-1:0]      i_col_index,
    input  lag_pkg::t_dp_cmd               i_cmd,
    output lag_pkg::t_dp_stat              o_stat,
    output logic [lag_pkg::ROW_BITS_W-1:0] o_row_bits,
    output logic                           o_op_done
);

    localparam int ROW_W    = $clog2(GRID_ROWS);
    localparam int CNT_W    = $clog2(GRID_ROWS + 3);
    localparam int LAST_CNT = GRID_ROWS + 2;
    localparam int WR_LAG   = 3;

    lag_pkg::t_req              r_req;
    logic [lag_pkg::IDX_W-1:0]  r_row;
    logic [lag_pkg::IDX_W-1:0]  r_col;
    logic [CNT_W-1:0]           r_cnt;
    logic [GRID_COLS-1:0]       r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0]       r_valid;
    logic [GRID_COLS-1:0]       r_rd_data;
    logic                       r_rd_live;
    logic [GRID_COLS-1:0]       r_prev;
    logic [GRID_COLS-1:0]       r_cur;
    logic [GRID_COLS-1:0]       r_next;
    logic [lag_pkg::ROW_BITS_W-1:0] r_row_bits;
    logic                       r_op_done;

    logic                 row_ok;
    logic                 col_ok;
    logic [ROW_W-1:0]     req_addr;
    logic [ROW_W-1:0]     step_rd_addr;
    logic [ROW_W-1:0]     step_wr_addr;
    logic [CNT_W-1:0]     cnt_lag;
    logic                 step_rd;
    logic                 step_wr;
    logic [GRID_COLS-1:0] rd_row;
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [GRID_COLS-1:0] wr_data;
    logic [GRID_COLS-1:0] life_row;
    logic [GRID_COLS+1:0] pad_prev;
    logic [GRID_COLS+1:0] pad_cur;
    logic [GRID_COLS+1:0] pad_next;
    logic [3:0]           nbr;

    assign row_ok       = int'(r_row) < GRID_ROWS;
    assign col_ok       = int'(r_col) < GRID_COLS;
    assign req_addr     = ROW_W'(r_row);
    assign step_rd      = int'(r_cnt) < GRID_ROWS;
    assign step_wr      = int'(r_cnt) >= WR_LAG;
    assign cnt_lag      = r_cnt - CNT_W'(WR_LAG);
    assign step_rd_addr = r_cnt[ROW_W-1:0];
    assign step_wr_addr = cnt_lag[ROW_W-1:0];
    assign rd_row       = r_rd_data & {GRID_COLS{r_rd_live}};

    // window holds rows c-4, c-3, c-2 during sweep cycle c; write back row c-3
    always_comb begin
        pad_prev = {1'b0, r_prev, 1'b0};
        pad_cur  = {1'b0, r_cur, 1'b0};
        pad_next = {1'b0, r_next, 1'b0};
        nbr      = '0;
        life_row = '0;
        for (int j = 0; j < GRID_COLS; j++) begin
            nbr = 4'(pad_prev[j]) + 4'(pad_prev[j+1]) + 4'(pad_prev[j+2])
                + 4'(pad_cur[j]) + 4'(pad_cur[j+2])
                + 4'(pad_next[j]) + 4'(pad_next[j+1]) + 4'(pad_next[j+2]);
            life_row[j] = (nbr == 4'd3) || (pad_cur[j+1] && nbr == 4'd2);
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = req_addr;
        if (i_cmd.set_read || i_cmd.read_row) begin
            rd_en = 1'b1;
        end else if (i_cmd.step_run && step_rd) begin
            rd_en   = 1'b1;
            rd_addr = step_rd_addr;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = req_addr;
        wr_data = rd_row | (GRID_COLS'(1) << r_col);
        if (i_cmd.set_write && row_ok && col_ok) begin
            wr_en = 1'b1;
        end else if (i_cmd.step_run && step_wr) begin
            wr_en   = 1'b1;
            wr_addr = step_wr_addr;
            wr_data = life_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // a row that is not valid reads as dead; drop the read data at capture so
    // the row above the top edge enters the window as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_live <= r_valid[rd_addr];
            end else if (i_cmd.step_run || i_cmd.capture) begin
                r_rd_live <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_cnt <= '0;
        end else if (i_cmd.step_run) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= lag_pkg::t_req'(i_req_type);
            r_row  <= i_row_index;
            r_col  <= i_col_index;
            r_prev <= '0;
            r_cur  <= '0;
            r_next <= '0;
        end else if (i_cmd.step_run) begin
            r_prev <= r_cur;
            r_cur  <= r_next;
            r_next <= rd_row;
        end
        if (i_cmd.load_out) begin
            r_row_bits <= (r_req == lag_pkg::REQ_READ && row_ok) ?
                          lag_pkg::ROW_BITS_W'(rd_row) : '0;
            r_op_done  <= 1'b1;
        end
    end

    assign o_stat.step_last = (r_cnt == CNT_W'(LAST_CNT));
    assign o_row_bits       = r_row_bits;
    assign o_op_done        = r_op_done;

endmodule

@@ design/lag_ctrl.sv @@
module lag_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [lag_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  lag_pkg::t_dp_stat         i_stat,
    output lag_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_SET_RD,
        ST_SET_WR,
        ST_READ,
        ST_STEP,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   load;

    assign load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.clear_all = (r_state == ST_CLR);
        o_cmd.set_read  = (r_state == ST_SET_RD);
        o_cmd.set_write = (r_state == ST_SET_WR);
        o_cmd.read_row  = (r_state == ST_READ);
        o_cmd.step_run  = (r_state == ST_STEP);
        o_cmd.load_out  = load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        case (lag_pkg::t_req'(i_req_type))
                            lag_pkg::REQ_SET:   r_state <= ST_SET_RD;
                            lag_pkg::REQ_CLEAR: r_state <= ST_CLR;
                            lag_pkg::REQ_STEP:  r_state <= ST_STEP;
                            lag_pkg::REQ_READ:  r_state <= ST_READ;
                            default:            r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_CLR:    r_state <= ST_DONE;
                ST_SET_RD: r_state <= ST_SET_WR;
                ST_SET_WR: r_state <= ST_DONE;
                ST_READ:   r_state <= ST_DONE;
                ST_STEP: begin
                    if (i_stat.step_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/lag_chk.sv @@
module lag_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [lag_pkg::ROW_BITS_W-1:0] o_row_bits,
    input logic                           o_op_done
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_row_bits))
        else $error("result dropped or changed while stalled");

    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_op_done)
        else $error("result without op_done");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind life_automaton_grid_core lag_chk u_lag_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_row_bits  (o_row_bits),
    .o_op_done   (o_op_done)
);
